// ===== design/fan_thermostat_with_dwell_timers_core_assert.svh =====
// Assertion macros for the fan thermostat core.
`ifndef FAN_THERMOSTAT_WITH_DWELL_TIMERS_CORE_ASSERT_SVH
`define FAN_THERMOSTAT_WITH_DWELL_TIMERS_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define FTDT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("ftdt assertion failed");
`define FTDT_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("ftdt assertion failed");
`else
`define FTDT_ASSERT(lbl, prop)
`define FTDT_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== design/ftdt_pkg.sv =====
// Types and constants for the fan thermostat core.
`timescale 1ns / 1ps
package ftdt_pkg;

  localparam int unsigned TIME_BITS_DEF = 32;
  localparam int unsigned TEMP_W        = 15;
  localparam int unsigned DUR_W         = 32;
  localparam int unsigned CFG_IDX_W     = 2;

  localparam logic signed [TEMP_W-1:0] HIGH_THR_RST = 15'sd3000;
  localparam logic signed [TEMP_W-1:0] LOW_THR_RST  = 15'sd2500;
  localparam logic [DUR_W-1:0]         HOLD_RST     = 32'd60000000;
  localparam logic [DUR_W-1:0]         MAX_VENT_RST = 32'd120000000;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_ALERT = 2'd1,
    MODE_VENT  = 2'd2
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HIGH_THR = 2'd0,
    REG_LOW_THR  = 2'd1,
    REG_HOLD     = 2'd2,
    REG_MAX_VENT = 2'd3
  } cfg_reg_e;

endpackage

// ===== design/fan_thermostat_with_dwell_timers_core.sv =====
// Fan thermostat with over-temperature and vent dwell timers.
//
//   channel  direction  handshake                 payload
//   in       sink       in_valid_i / in_ready_o    temperature_i, now_us_i
//   out      source     out_valid_o / out_ready_i  mode_o, fan_on_o
//   cfg      sink       cfg_we_i                   cfg_idx_i, cfg_wdata_i
//
// One item per cycle sustained while the output is not stalled; an item passes the
// input register, then the mode/timer update into the result register.
// The mode update is two temperature compares and two TIME_BITS subtracts, each
// compared with its duration, per item.
// Reset clears mode, timers, thresholds and durations to their defaults.
// An output stall holds the result; one more item waits in the input register.
`timescale 1ns / 1ps
`include "fan_thermostat_with_dwell_timers_core_assert.svh"
module fan_thermostat_with_dwell_timers_core #(
  parameter int unsigned TIME_BITS = ftdt_pkg::TIME_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [ftdt_pkg::TEMP_W-1:0]    temperature_i,
  input  logic [31:0]                           now_us_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [1:0]                            mode_o,
  output logic                                  fan_on_o,
  input  logic                                  cfg_we_i,
  input  logic [ftdt_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [ftdt_pkg::DUR_W-1:0]            cfg_wdata_i
);
  import ftdt_pkg::*;

  localparam int unsigned CmpW = (TIME_BITS > DUR_W) ? TIME_BITS : DUR_W;

  logic signed [TEMP_W-1:0] high_thr_q, low_thr_q;
  logic [DUR_W-1:0]         hold_q, max_vent_q;

  logic                     in_vld_q;
  logic signed [TEMP_W-1:0] temp_q;
  logic [TIME_BITS-1:0]     now_q;

  mode_e                    mode_q, mode_d;
  logic                     counting_q, counting_d;
  logic                     fan_q, fan_d;
  logic [TIME_BITS-1:0]     ot_start_q, ot_start_d;
  logic [TIME_BITS-1:0]     vent_start_q, vent_start_d;

  logic                     out_vld_q;
  mode_e                    out_mode_q;
  logic                     out_fan_q;

  logic                     res_free, step;
  logic [CmpW-1:0]          now_ext;
  logic [TIME_BITS-1:0]     ot_elapsed, vent_elapsed;
  logic                     over_high, under_low, hold_met, vent_met;

  assign res_free   = !out_vld_q || out_ready_i;
  assign step       = in_vld_q && res_free;
  assign in_ready_o = !in_vld_q || res_free;
  assign now_ext    = CmpW'(now_us_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_thr_q <= HIGH_THR_RST;
      low_thr_q  <= LOW_THR_RST;
      hold_q     <= HOLD_RST;
      max_vent_q <= MAX_VENT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_HIGH_THR: high_thr_q <= cfg_wdata_i[TEMP_W-1:0];
        REG_LOW_THR:  low_thr_q  <= cfg_wdata_i[TEMP_W-1:0];
        REG_HOLD:     hold_q     <= cfg_wdata_i;
        REG_MAX_VENT: max_vent_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      temp_q <= temperature_i;
      now_q  <= TIME_BITS'(now_ext);
    end
  end

  assign ot_elapsed   = TIME_BITS'(now_q - ot_start_q);
  assign vent_elapsed = TIME_BITS'(now_q - vent_start_q);
  assign over_high    = temp_q > high_thr_q;
  assign under_low    = temp_q < low_thr_q;
  assign hold_met     = CmpW'(ot_elapsed) >= CmpW'(hold_q);
  assign vent_met     = CmpW'(vent_elapsed) >= CmpW'(max_vent_q);

  always_comb begin
    mode_d       = mode_q;
    counting_d   = counting_q;
    fan_d        = fan_q;
    ot_start_d   = ot_start_q;
    vent_start_d = vent_start_q;
    unique case (mode_q)
      MODE_ALERT: begin
        if (over_high) begin
          if (counting_q && hold_met) begin
            fan_d        = 1'b1;
            vent_start_d = now_q;
            counting_d   = 1'b0;
            mode_d       = MODE_VENT;
          end
        end else begin
          counting_d = 1'b0;
          mode_d     = MODE_IDLE;
        end
      end
      MODE_VENT: begin
        if (under_low || vent_met) begin
          fan_d  = 1'b0;
          mode_d = MODE_IDLE;
        end
      end
      default: begin
        mode_d = MODE_IDLE;
        if (over_high) begin
          ot_start_d = now_q;
          counting_d = 1'b1;
          mode_d     = MODE_ALERT;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_IDLE;
      counting_q   <= 1'b0;
      fan_q        <= 1'b0;
      ot_start_q   <= '0;
      vent_start_q <= '0;
      out_vld_q    <= 1'b0;
    end else begin
      if (step) begin
        mode_q       <= mode_d;
        counting_q   <= counting_d;
        fan_q        <= fan_d;
        ot_start_q   <= ot_start_d;
        vent_start_q <= vent_start_d;
      end
      if (res_free) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_mode_q <= mode_d;
      out_fan_q  <= fan_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign mode_o      = out_mode_q;
  assign fan_on_o    = out_fan_q;

  // fan drive and venting mode move together
  `FTDT_ASSERT_ALWAYS(a_fan_vent, fan_q == (mode_q == MODE_VENT))
  // over-temperature timer only runs in alert
  `FTDT_ASSERT(a_count_alert, counting_q |-> mode_q == MODE_ALERT)
  // an item stepped through the update always lands in the result register
  `FTDT_ASSERT(a_step_result, step |=> out_vld_q)
  // a pending item holds the input register while the result stalls
  `FTDT_ASSERT(a_in_hold, in_vld_q && !res_free |=> in_vld_q && $stable(now_q))

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the fan thermostat core with dwell timers.
`timescale 1ns / 1ps
module tb_top;
  import ftdt_pkg::*;

  typedef struct packed {
    mode_e mode;
    logic  fan;
  } ctrl_res_t;

  typedef struct {
    logic signed [14:0] temp;
    logic [31:0]        ts;
    bit                 typed;
    mode_e              mode;
    logic               fan;
  } dir_row_t;

  typedef struct {
    logic signed [14:0] high;
    logic signed [14:0] low;
    logic [31:0]        hold;
    logic [31:0]        vent;
    int unsigned        items;
    int unsigned        step_max;
    int unsigned        tx_pct;
    int unsigned        rx_pct;
    bit                 pressure;
  } phase_cfg_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic signed [14:0]  temperature_i;
  logic [31:0]         now_us_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [1:0]          mode_o;
  logic                fan_on_o;
  logic                cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [DUR_W-1:0]    cfg_wdata_i;

  fan_thermostat_with_dwell_timers_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .temperature_i (temperature_i),
    .now_us_i      (now_us_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .mode_o        (mode_o),
    .fan_on_o      (fan_on_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // thermostat shadow state and registers
  logic signed [14:0] thr_high;
  logic signed [14:0] thr_low;
  logic [31:0]        hold_us;
  logic [31:0]        vent_max_us;
  mode_e              cur_mode;
  logic [31:0]        ot_start;
  logic [31:0]        vent_start;
  logic               counting_ot;
  logic               fan_q;

  ctrl_res_t   pending_q[$];
  int unsigned fail_cnt;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned vent_entries;
  int unsigned rx_stall_pct;
  bit          hold_off_req;
  int unsigned stall_left;

  dir_row_t dir_rows [18] = '{
    '{15'sd2000,  32'd0,          1'b1, MODE_IDLE,  1'b0},
    '{15'sd3000,  32'd10,         1'b1, MODE_IDLE,  1'b0},
    '{15'sd3001,  32'd100,        1'b1, MODE_ALERT, 1'b0},
    '{15'h3fff,   32'd60000099,   1'b1, MODE_ALERT, 1'b0},
    '{15'sd3001,  32'd60000100,   1'b1, MODE_VENT,  1'b1},
    '{15'sd2500,  32'd60000200,   1'b1, MODE_VENT,  1'b1},
    '{15'h4000,   32'd60000300,   1'b1, MODE_IDLE,  1'b0},
    '{15'sd3000,  32'd60000400,   1'b1, MODE_IDLE,  1'b0},
    '{15'sd5000,  32'hffffff00,   1'b1, MODE_ALERT, 1'b0},
    '{15'sd5000,  32'd59999744,   1'b1, MODE_VENT,  1'b1},
    '{15'sd15000, 32'd179999743,  1'b1, MODE_VENT,  1'b1},
    '{15'sd15000, 32'd179999744,  1'b1, MODE_IDLE,  1'b0},
    '{15'sd3001,  32'd200000000,  1'b1, MODE_ALERT, 1'b0},
    '{15'sd2999,  32'd200000001,  1'b1, MODE_IDLE,  1'b0},
    '{-15'sd5000, 32'd0,          1'b1, MODE_IDLE,  1'b0},
    '{15'sd15000, 32'hffffffff,   1'b1, MODE_ALERT, 1'b0},
    '{15'sd15000, 32'hffffffff,   1'b0, MODE_IDLE,  1'b0},
    '{15'sd2000,  32'hffffffff,   1'b0, MODE_IDLE,  1'b0}
  };

  phase_cfg_t phases [6];

  function automatic ctrl_res_t thermostat_step(logic signed [14:0] t, logic [31:0] ts);
    ctrl_res_t   res;
    logic [31:0] el_ot;
    logic [31:0] el_vent;
    el_ot   = ts - ot_start;
    el_vent = ts - vent_start;
    case (cur_mode)
      MODE_ALERT: begin
        if (t > thr_high) begin
          if (counting_ot && el_ot >= hold_us) begin
            fan_q       = 1'b1;
            vent_start  = ts;
            counting_ot = 1'b0;
            cur_mode    = MODE_VENT;
            vent_entries++;
          end
        end else begin
          counting_ot = 1'b0;
          cur_mode    = MODE_IDLE;
        end
      end
      MODE_VENT: begin
        if (t < thr_low || el_vent >= vent_max_us) begin
          fan_q    = 1'b0;
          cur_mode = MODE_IDLE;
        end
      end
      default: begin
        cur_mode = MODE_IDLE;
        if (t > thr_high) begin
          ot_start    = ts;
          counting_ot = 1'b1;
          cur_mode    = MODE_ALERT;
        end
      end
    endcase
    res.mode = cur_mode;
    res.fan  = fan_q;
    return res;
  endfunction

  function automatic logic signed [14:0] pick_temp();
    int v;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45)      v = int'(thr_high) + int'($urandom_range(0, 400)) - 200;
    else if (r < 75) v = int'(thr_low) + int'($urandom_range(0, 400)) - 200;
    else if (r < 90) v = int'($urandom_range(0, 20000)) - 5000;
    else             v = int'($urandom_range(0, 32767)) - 16384;
    if (v > 16383) v = 16383;
    if (v < -16384) v = -16384;
    return v[14:0];
  endfunction

  task automatic send_item(logic signed [14:0] t, logic [31:0] ts, bit typed,
                           ctrl_res_t typed_res);
    ctrl_res_t p;
    in_valid_i    <= 1'b1;
    temperature_i <= t;
    now_us_i      <= ts;
    do @(posedge clk_i); while (!in_ready_o);
    p = thermostat_step(t, ts);
    pending_q.push_back(typed ? typed_res : p);
    items_sent++;
  endtask

  task automatic sender_gap(int unsigned pct);
    if ($urandom_range(0, 99) < pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < pct);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apply_settings(phase_cfg_t pc);
    logic [31:0] d;
    for (int k = 0; k < 4; k++) begin
      case (cfg_reg_e'(k))
        REG_HIGH_THR: d = {17'($urandom_range(0, 131071)), pc.high};
        REG_LOW_THR:  d = {17'($urandom_range(0, 131071)), pc.low};
        REG_HOLD:     d = pc.hold;
        default:      d = pc.vent;
      endcase
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= cfg_reg_e'(k);
      cfg_wdata_i <= d;
      @(posedge clk_i);
    end
    cfg_we_i    <= 1'b0;
    thr_high    = pc.high;
    thr_low     = pc.low;
    hold_us     = pc.hold;
    vent_max_us = pc.vent;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  // result side: random stalls plus one long hold-off on request
  initial begin
    out_ready_i = 1'b0;
    stall_left  = 0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left   = 47;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    ctrl_res_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (pending_q.size() == 0) begin
        $error("unexpected item: mode %0d fan_on %0d", mode_o, fan_on_o);
        fail_cnt++;
      end else begin
        e = pending_q.pop_front();
        if (mode_o !== e.mode) begin
          $error("mode: expected %0d, got %0d", e.mode, mode_o);
          fail_cnt++;
        end
        if (fan_on_o !== e.fan) begin
          $error("fan_on: expected %0d, got %0d", e.fan, fan_on_o);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    ctrl_res_t   tr;
    logic [31:0] ts;
    int unsigned r;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    temperature_i = '0;
    now_us_i      = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_HIGH_THR;
    cfg_wdata_i   = '0;
    rx_stall_pct  = 0;
    hold_off_req  = 1'b0;
    fail_cnt      = 0;
    items_sent    = 0;
    results_seen  = 0;
    vent_entries  = 0;
    thr_high      = HIGH_THR_RST;
    thr_low       = LOW_THR_RST;
    hold_us       = HOLD_RST;
    vent_max_us   = MAX_VENT_RST;
    cur_mode      = MODE_IDLE;
    ot_start      = '0;
    vent_start    = '0;
    counting_ot   = 1'b0;
    fan_q         = 1'b0;

    // high, low, hold, vent, items, step, tx idle, rx stall, hold-off
    phases[0] = '{15'sd3000, 15'sd2500, 32'd40, 32'd100, 200, 15, 0, 0, 1'b0};
    phases[1] = '{15'sd0, 15'sd0, 32'd0, 32'd0, 180, 3, 72, 0, 1'b0};
    phases[2] = '{-15'sd5000, 15'sd15000, 32'd7, 32'd20, 180, 4, 0, 72, 1'b0};
    phases[3] = '{15'h4000, 15'h4000, 32'hffffffff, 32'd0, 170, 5, 31, 31, 1'b0};
    phases[4] = '{15'sd2000, 15'sd1500, 32'd300, 32'd900, 240, 60, 0, 0, 1'b1};
    phases[5] = '{15'h3fff, 15'h3fff, 32'd1, 32'hffffffff, 60, 2, 0, 72, 1'b0};

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      tr.mode = dir_rows[i].mode;
      tr.fan  = dir_rows[i].fan;
      send_item(dir_rows[i].temp, dir_rows[i].ts, dir_rows[i].typed, tr);
    end

    ts = $urandom;
    foreach (phases[p]) begin
      drain();
      apply_settings(phases[p]);
      rx_stall_pct = phases[p].rx_pct;
      for (int n = 0; n < phases[p].items; n++) begin
        if (phases[p].pressure && n == 20) hold_off_req = 1'b1;
        sender_gap(phases[p].tx_pct);
        r = $urandom_range(0, 99);
        if (r < 4)      ts = $urandom;
        else if (r < 6) ts = 32'hffffffff - $urandom_range(0, 4 * phases[p].step_max);
        else            ts = ts + $urandom_range(0, phases[p].step_max);
        send_item(pick_temp(), ts, 1'b0, tr);
      end
    end
    drain();

    $display("Sent %0d evaluations over %0d register settings; %0d results checked.",
             items_sent, $size(phases) + 1, results_seen);
    $display("Predicted vent entries: %0d; mismatches: %0d.", vent_entries, fail_cnt);
    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
